// ===== rtl/rtvm_pkg.sv =====
// shared constants, codes and types of the regex thread machine matcher
package rtvm_pkg;

    localparam int PROG_DEPTH  = 64;
    localparam int MAX_THREADS = 64;
    localparam int MAX_SUBS    = 8;
    localparam int OFF_W       = 16;

    localparam int PC_W      = $clog2(PROG_DEPTH);
    localparam int TH_W      = $clog2(MAX_THREADS);
    localparam int CNT_W     = TH_W + 1;
    localparam int SUB_IX_W  = $clog2(MAX_SUBS);
    localparam int MS_W      = 4;
    localparam int STEP_W    = 16;
    localparam int CODE_W    = 21;
    localparam int OP_W      = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CODE_W-1:0] CH_NEWLINE = CODE_W'(10);

    localparam logic [OP_W-1:0] OP_RUNE   = 4'd0;
    localparam logic [OP_W-1:0] OP_ANY    = 4'd1;
    localparam logic [OP_W-1:0] OP_CLASS  = 4'd2;
    localparam logic [OP_W-1:0] OP_NOTNL  = 4'd3;
    localparam logic [OP_W-1:0] OP_BOL    = 4'd4;
    localparam logic [OP_W-1:0] OP_EOL    = 4'd5;
    localparam logic [OP_W-1:0] OP_JMP    = 4'd6;
    localparam logic [OP_W-1:0] OP_SPLIT  = 4'd7;
    localparam logic [OP_W-1:0] OP_SAVE   = 4'd8;
    localparam logic [OP_W-1:0] OP_UNSAVE = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGINS_LINE = 3'd4;

    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ACCEPT = 4'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PRD    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_EXEC   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FINISH = 4'd7;
    localparam logic [CMD_W-1:0] CMD_EMIT   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ADV    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_INIT   = 4'd10;

    localparam int OUT_W = 3;
    localparam logic [OUT_W-1:0] OUT_NEXT  = 3'd0;
    localparam logic [OUT_W-1:0] OUT_SPLIT = 3'd1;
    localparam logic [OUT_W-1:0] OUT_KEEP  = 3'd2;
    localparam logic [OUT_W-1:0] OUT_DIE   = 3'd3;
    localparam logic [OUT_W-1:0] OUT_CLASS = 3'd4;
    localparam logic [OUT_W-1:0] OUT_MATCH = 3'd5;

    typedef struct packed {
        logic [OFF_W-1:0] sp;
        logic [OFF_W-1:0] ep;
        logic             sset;
        logic             eset;
    } t_cap;

    typedef struct packed {
        logic [PC_W-1:0]          pc;
        logic [STEP_W-1:0]        gen;
        t_cap [MAX_SUBS-1:0]      caps;
    } t_thread;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] hi;
        logic [5:0]        ta;
        logic [5:0]        tb;
        logic [4:0]        sub;
    } t_instr;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic             any_thread;
        logic             brk;
        logic             visited;
        logic [OUT_W-1:0] outcome;
        logic             early_done;
        logic             at_end;
        logic             done;
        logic             last_res;
    } t_stat;

endpackage

// ===== rtl/rtvm_ctrl.sv =====
// sequencing state machine of the regex thread machine matcher
module rtvm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_command,
    input  logic          i_is_end,
    input  logic          i_out_stall,
    input  rtvm_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output rtvm_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BEGIN  = 4'd1;
    localparam logic [3:0] S_FETCH  = 4'd2;
    localparam logic [3:0] S_TAKE   = 4'd3;
    localparam logic [3:0] S_PRD    = 4'd4;
    localparam logic [3:0] S_EXEC   = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_WAIT   = 4'd8;
    localparam logic [3:0] S_INIT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.code = rtvm_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.code = rtvm_pkg::CMD_ACCEPT;
                    if (i_command) begin
                        if (i_is_end) begin
                            n_state = i_stat.done ? S_INIT : S_BEGIN;
                        end else begin
                            n_state = i_stat.done ? S_IDLE : S_BEGIN;
                        end
                    end
                end
            end
            S_BEGIN: begin
                o_cmd.code = rtvm_pkg::CMD_BEGIN;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.code = rtvm_pkg::CMD_FETCH;
                n_state    = i_stat.any_thread ? S_TAKE : S_FINISH;
            end
            S_TAKE: begin
                o_cmd.code = rtvm_pkg::CMD_TAKE;
                n_state    = i_stat.brk ? S_FINISH : S_PRD;
            end
            S_PRD: begin
                o_cmd.code = rtvm_pkg::CMD_PRD;
                n_state    = i_stat.visited ? S_FETCH : S_EXEC;
            end
            S_EXEC: begin
                o_cmd.code = rtvm_pkg::CMD_EXEC;
                if (i_stat.outcome == rtvm_pkg::OUT_NEXT ||
                    i_stat.outcome == rtvm_pkg::OUT_SPLIT ||
                    i_stat.outcome == rtvm_pkg::OUT_CLASS) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FINISH: begin
                o_cmd.code = rtvm_pkg::CMD_FINISH;
                n_state    = (i_stat.at_end || i_stat.early_done) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_cmd.code = rtvm_pkg::CMD_EMIT;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (!i_out_stall) begin
                    if (i_stat.last_res) begin
                        n_state = i_stat.at_end ? S_INIT : S_IDLE;
                    end else begin
                        o_cmd.code = rtvm_pkg::CMD_ADV;
                        n_state    = S_EMIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.code = rtvm_pkg::CMD_INIT;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_WAIT);

endmodule

// ===== rtl/rtvm_dp.sv =====
// datapath of the regex thread machine matcher: program, thread lists, captures
module rtvm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rtvm_pkg::t_cmd                  i_cmd,
    input  logic                            i_cfg_we,
    input  logic [rtvm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtvm_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_command,
    input  logic [5:0]                      i_instr_index,
    input  logic [3:0]                      i_instr_op,
    input  logic [20:0]                     i_instr_low,
    input  logic [20:0]                     i_instr_high,
    input  logic [5:0]                      i_instr_target_a,
    input  logic [5:0]                      i_instr_target_b,
    input  logic [4:0]                      i_instr_sub,
    input  logic [20:0]                     i_char_code,
    input  logic [2:0]                      i_char_bytes,
    input  logic                            i_is_end,
    output rtvm_pkg::t_stat                 o_stat,
    output logic                            o_matched,
    output logic [2:0]                      o_slot,
    output logic [rtvm_pkg::OFF_W-1:0]      o_cap_start,
    output logic [rtvm_pkg::OFF_W-1:0]      o_cap_end,
    output logic                            o_start_set,
    output logic                            o_end_set,
    output logic                            o_last
);

    localparam int TM_DEPTH = 3 * rtvm_pkg::MAX_THREADS;
    localparam int TM_AW    = $clog2(TM_DEPTH);
    localparam int CW       = rtvm_pkg::CNT_W;
    localparam int PW       = rtvm_pkg::PC_W;
    localparam logic [1:0] RG_STACK = 2'd2;
    localparam int SUB_IX_W_L = rtvm_pkg::SUB_IX_W;

    // configuration
    logic [PW-1:0]                  r_start_pc;
    logic [rtvm_pkg::MS_W-1:0]      r_cap_count;
    logic                           r_hard_end;
    logic [rtvm_pkg::OFF_W-1:0]     r_start_off;
    logic                           r_begins_line;

    // memories
    rtvm_pkg::t_instr  r_prog [rtvm_pkg::PROG_DEPTH];
    rtvm_pkg::t_instr  r_prog_rd;
    rtvm_pkg::t_thread r_tmem [TM_DEPTH];
    rtvm_pkg::t_thread r_tm_rd;

    // search state
    logic [rtvm_pkg::PROG_DEPTH-1:0]    r_visit;
    logic                               r_cur_sel;
    logic [CW-1:0]                      r_cnt;
    logic [CW-1:0]                      r_nc;
    logic [CW-1:0]                      r_pos;
    logic [CW-1:0]                      r_stk;
    logic                               r_start_pend;
    logic                               r_first;
    logic                               r_src_start;
    logic [rtvm_pkg::STEP_W-1:0]        r_step;
    logic [rtvm_pkg::OFF_W-1:0]         r_off;
    logic                               r_prev_nl;
    logic [rtvm_pkg::STEP_W-1:0]        r_match_step;
    rtvm_pkg::t_cap [rtvm_pkg::MAX_SUBS-1:0] r_match_caps;
    logic                               r_done;

    // working thread
    logic [PW-1:0]                      r_pc;
    logic [rtvm_pkg::STEP_W-1:0]        r_gen;
    rtvm_pkg::t_cap [rtvm_pkg::MAX_SUBS-1:0] r_caps;
    logic                               r_cls;
    logic [PW-1:0]                      r_q;
    logic [PW:0]                        r_n;

    // current item
    logic [rtvm_pkg::CODE_W-1:0]        r_r;
    logic                               r_at_end;
    logic [2:0]                         r_bytes;
    logic [rtvm_pkg::MS_W-1:0]          r_k;

    logic [rtvm_pkg::MS_W-1:0]          w_ms;
    logic [rtvm_pkg::MS_W-1:0]          w_n_res;
    logic                               w_use;
    rtvm_pkg::t_cap                     w_res_cap;
    rtvm_pkg::t_instr                   w_in;
    logic [PW-1:0]                      w_pc_inc;
    logic [PW-1:0]                      w_new_pc;
    logic [PW-1:0]                      w_new_q;
    logic [PW:0]                        w_n_next;
    logic [rtvm_pkg::OUT_W-1:0]         w_out;
    logic                               w_sub_ok;
    logic [SUB_IX_W_L-1:0]              w_sub_ix;
    rtvm_pkg::t_cap                     w_cap_upd;
    rtvm_pkg::t_cap [rtvm_pkg::MAX_SUBS-1:0] w_match_caps;
    logic [CW+1:0]                      w_room_sum;
    logic                               w_room;
    logic                               w_any;
    rtvm_pkg::t_thread                  w_take;
    logic                               w_exec;
    logic                               w_push;
    logic                               w_keep;
    logic                               w_tm_we;
    logic [TM_AW-1:0]                   w_tm_waddr;
    rtvm_pkg::t_thread                  w_tm_wdata;
    logic                               w_tm_re;
    logic [TM_AW-1:0]                   w_tm_raddr;
    logic [rtvm_pkg::OFF_W:0]           w_off_sum;
    logic [rtvm_pkg::OFF_W-1:0]         w_new_start_off;
    logic                               w_new_begins;

    function automatic logic [TM_AW-1:0] f_addr(input logic [1:0] rg,
                                                input logic [rtvm_pkg::TH_W-1:0] ix);
        return TM_AW'(rg) * TM_AW'(rtvm_pkg::MAX_THREADS) + TM_AW'(ix);
    endfunction

    assign w_ms    = (r_cap_count > rtvm_pkg::MS_W'(rtvm_pkg::MAX_SUBS)) ?
                     rtvm_pkg::MS_W'(rtvm_pkg::MAX_SUBS) : r_cap_count;
    assign w_n_res = (w_ms == '0) ? rtvm_pkg::MS_W'(1) : w_ms;
    assign w_use   = (w_ms != '0);
    assign w_res_cap = r_match_caps[r_k[SUB_IX_W_L-1:0]];

    // instruction evaluation
    assign w_in     = r_prog_rd;
    assign w_pc_inc = r_pc + 1'b1;
    assign w_n_next = r_n + 1'b1;
    assign w_new_q  = r_cls ? (r_q + 1'b1) : w_pc_inc;
    assign w_sub_ok = ({1'b0, w_ms} > w_in.sub);
    assign w_sub_ix = w_in.sub[SUB_IX_W_L-1:0];

    always_comb begin
        w_cap_upd = r_caps[w_sub_ix];
        if (w_in.op == rtvm_pkg::OP_SAVE) begin
            w_cap_upd.sp   = r_off;
            w_cap_upd.sset = 1'b1;
        end else begin
            w_cap_upd.ep   = r_off;
            w_cap_upd.eset = 1'b1;
        end
    end

    always_comb begin
        w_match_caps         = r_caps;
        w_match_caps[0].ep   = r_off;
        w_match_caps[0].eset = 1'b1;
    end

    always_comb begin
        w_out    = rtvm_pkg::OUT_DIE;
        w_new_pc = r_pc;
        if (r_cls || w_in.op == rtvm_pkg::OP_CLASS) begin
            if (r_r < w_in.lo) begin
                w_out = rtvm_pkg::OUT_DIE;
            end else if (r_r > w_in.hi) begin
                w_out = (w_n_next == (PW+1)'(rtvm_pkg::PROG_DEPTH)) ?
                        rtvm_pkg::OUT_DIE : rtvm_pkg::OUT_CLASS;
            end else begin
                w_out    = rtvm_pkg::OUT_KEEP;
                w_new_pc = PW'(w_in.ta);
            end
        end else begin
            case (w_in.op)
                rtvm_pkg::OP_RUNE: begin
                    if (r_r == w_in.lo) begin
                        w_out    = rtvm_pkg::OUT_KEEP;
                        w_new_pc = w_pc_inc;
                    end
                end
                rtvm_pkg::OP_ANY: begin
                    w_out    = rtvm_pkg::OUT_KEEP;
                    w_new_pc = w_pc_inc;
                end
                rtvm_pkg::OP_NOTNL: begin
                    if (r_r != rtvm_pkg::CH_NEWLINE) begin
                        w_out    = rtvm_pkg::OUT_NEXT;
                        w_new_pc = w_pc_inc;
                    end
                end
                rtvm_pkg::OP_BOL: begin
                    if (r_prev_nl) begin
                        w_out    = rtvm_pkg::OUT_NEXT;
                        w_new_pc = w_pc_inc;
                    end
                end
                rtvm_pkg::OP_EOL: begin
                    if ((!r_at_end && r_r == rtvm_pkg::CH_NEWLINE) ||
                        (r_at_end && r_hard_end)) begin
                        w_out    = rtvm_pkg::OUT_NEXT;
                        w_new_pc = w_pc_inc;
                    end
                end
                rtvm_pkg::OP_JMP: begin
                    w_out    = rtvm_pkg::OUT_NEXT;
                    w_new_pc = PW'(w_in.ta);
                end
                rtvm_pkg::OP_SPLIT: begin
                    w_out    = rtvm_pkg::OUT_SPLIT;
                    w_new_pc = PW'(w_in.ta);
                end
                rtvm_pkg::OP_SAVE: begin
                    w_out    = rtvm_pkg::OUT_NEXT;
                    w_new_pc = w_pc_inc;
                end
                rtvm_pkg::OP_UNSAVE: begin
                    if (w_in.sub == '0) begin
                        w_out = rtvm_pkg::OUT_MATCH;
                    end else begin
                        w_out    = rtvm_pkg::OUT_NEXT;
                        w_new_pc = w_pc_inc;
                    end
                end
                default: begin
                    w_out = rtvm_pkg::OUT_DIE;
                end
            endcase
        end
    end

    // pool room for a split branch: pending threads, this one and the next list
    assign w_room_sum = (CW+2)'(r_stk) + (CW+2)'(r_cnt - r_pos) + (CW+2)'(r_start_pend)
                      + (CW+2)'(r_nc) + (CW+2)'(1);
    assign w_room = (w_room_sum < (CW+2)'(rtvm_pkg::MAX_THREADS));

    assign w_any = (r_stk != '0) || (r_pos < r_cnt) || r_start_pend;

    always_comb begin
        if (r_src_start) begin
            w_take.pc   = r_start_pc;
            w_take.gen  = r_step;
            w_take.caps = '0;
        end else begin
            w_take = r_tm_rd;
        end
    end

    assign w_exec = (i_cmd.code == rtvm_pkg::CMD_EXEC);
    assign w_push = w_exec && (w_out == rtvm_pkg::OUT_SPLIT) && w_room;
    assign w_keep = w_exec && (w_out == rtvm_pkg::OUT_KEEP) &&
                    (r_nc < CW'(rtvm_pkg::MAX_THREADS));
    assign w_tm_we = w_push || w_keep;

    always_comb begin
        w_tm_wdata.gen  = r_gen;
        w_tm_wdata.caps = r_caps;
        if (w_push) begin
            w_tm_waddr    = f_addr(RG_STACK, r_stk[rtvm_pkg::TH_W-1:0]);
            w_tm_wdata.pc = PW'(w_in.tb);
        end else begin
            w_tm_waddr    = f_addr({1'b0, ~r_cur_sel}, r_nc[rtvm_pkg::TH_W-1:0]);
            w_tm_wdata.pc = w_new_pc;
        end
    end

    assign w_tm_re = (i_cmd.code == rtvm_pkg::CMD_FETCH) &&
                     ((r_stk != '0) || (r_pos < r_cnt));

    always_comb begin
        if (r_stk != '0) begin
            w_tm_raddr = f_addr(RG_STACK, r_stk[rtvm_pkg::TH_W-1:0] - 1'b1);
        end else begin
            w_tm_raddr = f_addr({1'b0, r_cur_sel}, r_pos[rtvm_pkg::TH_W-1:0]);
        end
    end

    assign w_off_sum = {1'b0, r_off} + (rtvm_pkg::OFF_W+1)'(r_bytes);

    assign w_new_start_off = (i_cfg_index == rtvm_pkg::CFG_START_OFF) ?
                             rtvm_pkg::OFF_W'(i_cfg_data) : r_start_off;
    assign w_new_begins    = (i_cfg_index == rtvm_pkg::CFG_BEGINS_LINE) ?
                             i_cfg_data[0] : r_begins_line;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == rtvm_pkg::CMD_ACCEPT && !i_command) begin
            r_prog[PW'(i_instr_index)] <= '{op: i_instr_op, lo: i_instr_low,
                                            hi: i_instr_high, ta: i_instr_target_a,
                                            tb: i_instr_target_b, sub: i_instr_sub};
        end
        if (i_cmd.code == rtvm_pkg::CMD_PRD) begin
            r_prog_rd <= r_prog[r_cls ? r_q : r_pc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tm_we) begin
            r_tmem[w_tm_waddr] <= w_tm_wdata;
        end
        if (w_tm_re) begin
            r_tm_rd <= r_tmem[w_tm_raddr];
        end
    end

    // control and search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc    <= '0;
            r_cap_count   <= rtvm_pkg::MS_W'(1);
            r_hard_end    <= 1'b1;
            r_start_off   <= '0;
            r_begins_line <= 1'b1;
            r_visit       <= '0;
            r_cur_sel     <= 1'b0;
            r_cnt         <= '0;
            r_nc          <= '0;
            r_pos         <= '0;
            r_stk         <= '0;
            r_start_pend  <= 1'b0;
            r_first       <= 1'b0;
            r_src_start   <= 1'b0;
            r_step        <= '0;
            r_off         <= '0;
            r_prev_nl     <= 1'b1;
            r_match_step  <= '0;
            r_match_caps  <= '0;
            r_done        <= 1'b0;
            r_cls         <= 1'b0;
            r_n           <= '0;
            r_k           <= '0;
        end else begin
            case (i_cmd.code)
                rtvm_pkg::CMD_ACCEPT: begin
                    r_r      <= i_is_end ? '0 : i_char_code;
                    r_at_end <= i_is_end;
                    r_bytes  <= i_char_bytes;
                end
                rtvm_pkg::CMD_BEGIN: begin
                    if (r_step != '1) begin
                        r_step <= r_step + 1'b1;
                    end
                    r_visit      <= '0;
                    r_pos        <= '0;
                    r_stk        <= '0;
                    r_nc         <= '0;
                    r_first      <= 1'b1;
                    r_start_pend <= (r_match_step == '0) &&
                                    (r_cnt < CW'(rtvm_pkg::MAX_THREADS));
                end
                rtvm_pkg::CMD_FETCH: begin
                    if (r_stk != '0) begin
                        r_stk       <= r_stk - 1'b1;
                        r_src_start <= 1'b0;
                    end else if (r_pos < r_cnt) begin
                        r_pos       <= r_pos + 1'b1;
                        r_src_start <= 1'b0;
                    end else if (r_start_pend) begin
                        r_start_pend <= 1'b0;
                        r_src_start  <= 1'b1;
                    end
                end
                rtvm_pkg::CMD_TAKE: begin
                    r_pc    <= w_take.pc;
                    r_gen   <= w_take.gen;
                    r_caps  <= w_take.caps;
                    r_first <= 1'b0;
                    r_cls   <= 1'b0;
                    r_n     <= '0;
                end
                rtvm_pkg::CMD_PRD: begin
                    if (!r_cls) begin
                        r_visit[r_pc] <= 1'b1;
                    end
                end
                rtvm_pkg::CMD_EXEC: begin
                    r_pc <= w_new_pc;
                    if (w_out == rtvm_pkg::OUT_CLASS) begin
                        r_cls <= 1'b1;
                        r_q   <= w_new_q;
                        r_n   <= w_n_next;
                    end
                    if (!r_cls && w_out == rtvm_pkg::OUT_NEXT && w_sub_ok &&
                        (w_in.op == rtvm_pkg::OP_SAVE || w_in.op == rtvm_pkg::OP_UNSAVE)) begin
                        r_caps[w_sub_ix] <= w_cap_upd;
                    end
                    if (w_out == rtvm_pkg::OUT_MATCH) begin
                        r_match_step <= r_gen;
                        if (w_use) begin
                            r_match_caps <= w_match_caps;
                        end
                    end
                    if (w_push) begin
                        r_stk <= r_stk + 1'b1;
                    end
                    if (w_keep) begin
                        r_nc <= r_nc + 1'b1;
                    end
                end
                rtvm_pkg::CMD_FINISH: begin
                    r_cur_sel <= ~r_cur_sel;
                    r_cnt     <= r_nc;
                    r_k       <= '0;
                    if (!r_at_end) begin
                        r_off     <= w_off_sum[rtvm_pkg::OFF_W] ? '1 :
                                     w_off_sum[rtvm_pkg::OFF_W-1:0];
                        r_prev_nl <= (r_r == rtvm_pkg::CH_NEWLINE);
                        if (r_match_step != '0 && r_nc == '0) begin
                            r_done <= 1'b1;
                        end
                    end
                end
                rtvm_pkg::CMD_ADV: begin
                    r_k <= r_k + 1'b1;
                end
                rtvm_pkg::CMD_INIT: begin
                    r_visit      <= '0;
                    r_cnt        <= '0;
                    r_nc         <= '0;
                    r_cur_sel    <= 1'b0;
                    r_step       <= '0;
                    r_match_step <= '0;
                    r_match_caps <= '0;
                    r_done       <= 1'b0;
                    r_off        <= r_start_off;
                    r_prev_nl    <= r_begins_line;
                end
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rtvm_pkg::CFG_START_PC:    r_start_pc    <= PW'(i_cfg_data);
                    rtvm_pkg::CFG_CAP_COUNT:   r_cap_count   <= rtvm_pkg::MS_W'(i_cfg_data);
                    rtvm_pkg::CFG_HARD_END:    r_hard_end    <= i_cfg_data[0];
                    rtvm_pkg::CFG_START_OFF:   r_start_off   <= rtvm_pkg::OFF_W'(i_cfg_data);
                    rtvm_pkg::CFG_BEGINS_LINE: r_begins_line <= i_cfg_data[0];
                    default: begin
                    end
                endcase
                if (r_step == '0 && !r_done && i_cfg_index <= rtvm_pkg::CFG_BEGINS_LINE) begin
                    r_off     <= w_new_start_off;
                    r_prev_nl <= w_new_begins;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.code == rtvm_pkg::CMD_EMIT) begin
            o_matched   <= (r_match_step != '0);
            o_slot      <= 3'(r_k);
            o_cap_start <= w_use ? w_res_cap.sp : '0;
            o_cap_end   <= w_use ? w_res_cap.ep : '0;
            o_start_set <= w_use && w_res_cap.sset;
            o_end_set   <= w_use && w_res_cap.eset;
            o_last      <= ((r_k + 1'b1) == w_n_res);
        end
    end

    assign o_stat.any_thread = w_any;
    assign o_stat.brk        = !r_first && (r_match_step != '0) && (w_take.gen > r_match_step);
    assign o_stat.visited    = !r_cls && r_visit[r_pc];
    assign o_stat.outcome    = w_out;
    assign o_stat.early_done = !r_at_end && (r_match_step != '0) && (r_nc == '0);
    assign o_stat.at_end     = r_at_end;
    assign o_stat.done       = r_done;
    assign o_stat.last_res   = ((r_k + 1'b1) == w_n_res);

`ifndef SYNTH
    a_nc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nc <= CW'(rtvm_pkg::MAX_THREADS))
        else $error("next list count beyond pool size");
    a_match_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_step <= r_step)
        else $error("match step ahead of step count");
    a_done_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_match_step != '0))
        else $error("search finished without a match");
    a_take_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == rtvm_pkg::CMD_TAKE) |=> !r_cls)
        else $error("class walk not cleared on new thread");
`endif

endmodule

// ===== rtl/regex_thread_vm_matcher_top.sv =====
// top level of the regex thread machine matcher
//  channel | direction | handshake          | payload
//  items   | in        | i_valid / o_stall  | command, instruction fields, character
//  results | out       | o_valid / i_stall  | match status and one capture slot
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
// a program load is written while idle; a character runs a begin step, then for each
//  thread fetch and take, then read and execute per instruction or class step, and finish
// each result is registered on emit and held valid until taken; an end item adds a restart
// reset is synchronous active low and clears the search and configuration, not the program
// o_stall is high while not idle: through a character's search, results and any restart
module regex_thread_vm_matcher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [5:0]                      i_instr_index,
    input  logic [3:0]                      i_instr_op,
    input  logic [20:0]                     i_instr_low,
    input  logic [20:0]                     i_instr_high,
    input  logic [5:0]                      i_instr_target_a,
    input  logic [5:0]                      i_instr_target_b,
    input  logic [4:0]                      i_instr_sub,
    input  logic [20:0]                     i_char_code,
    input  logic [2:0]                      i_char_bytes,
    input  logic                            i_is_end,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_matched,
    output logic [2:0]                      o_slot,
    output logic [rtvm_pkg::OFF_W-1:0]      o_cap_start,
    output logic [rtvm_pkg::OFF_W-1:0]      o_cap_end,
    output logic                            o_start_set,
    output logic                            o_end_set,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [rtvm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtvm_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    rtvm_pkg::t_cmd  w_cmd;
    rtvm_pkg::t_stat w_stat;

    rtvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_is_end    (i_is_end),
        .i_out_stall (i_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    rtvm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_instr_index    (i_instr_index),
        .i_instr_op       (i_instr_op),
        .i_instr_low      (i_instr_low),
        .i_instr_high     (i_instr_high),
        .i_instr_target_a (i_instr_target_a),
        .i_instr_target_b (i_instr_target_b),
        .i_instr_sub      (i_instr_sub),
        .i_char_code      (i_char_code),
        .i_char_bytes     (i_char_bytes),
        .i_is_end         (i_is_end),
        .o_stat           (w_stat),
        .o_matched        (o_matched),
        .o_slot           (o_slot),
        .o_cap_start      (o_cap_start),
        .o_cap_end        (o_cap_end),
        .o_start_set      (o_start_set),
        .o_end_set        (o_end_set),
        .o_last           (o_last)
    );

endmodule

// ===== bench/regex_thread_vm_matcher_top_test.sv =====
// self-checking testbench for the regex thread machine matcher top level
`timescale 1ns / 100ps

module regex_thread_vm_matcher_top_test;

    typedef struct {
        bit        cmd;
        bit [5:0]  idx;
        bit [3:0]  op;
        bit [20:0] lo;
        bit [20:0] hi;
        bit [5:0]  ta;
        bit [5:0]  tb;
        bit [4:0]  sub;
        bit [20:0] code;
        bit [2:0]  nbytes;
        bit        is_end;
    } item_s;

    typedef struct {
        bit        matched;
        bit [2:0]  slot;
        bit [15:0] cap_start;
        bit [15:0] cap_end;
        bit        start_set;
        bit        end_set;
        bit        last;
    } capture_s;

    typedef struct {
        bit [5:0]       pc;
        bit [15:0]      gen;
        rtvm_pkg::t_cap caps [rtvm_pkg::MAX_SUBS];
    } thread_s;

    class match_scoreboard;
        rtvm_pkg::t_instr prog [rtvm_pkg::PROG_DEPTH];
        bit [63:0]   visited;
        thread_s     lists [2][160];
        int unsigned cnt [2];
        int unsigned cur;
        int unsigned steps, offset, mstep;
        bit          prev_nl, done;
        rtvm_pkg::t_cap mcap [rtvm_pkg::MAX_SUBS];
        bit [5:0]    start_pc;
        bit [3:0]    cap_count;
        bit          hard_end, begins_line;
        bit [15:0]   start_off;
        capture_s    expected_caps [$];
        int          errors;

        function int unsigned cap_slots();
            return (cap_count > rtvm_pkg::MAX_SUBS) ? rtvm_pkg::MAX_SUBS : cap_count;
        endfunction

        function void load_string();
            offset  = start_off;
            prev_nl = begins_line;
        endfunction

        function void init_search();
            visited = '0;
            cnt[0] = 0;
            cnt[1] = 0;
            cur = 0;
            steps = 0;
            mstep = 0;
            foreach (mcap[k]) mcap[k] = '0;
            done = 0;
            load_string();
        endfunction

        function void reset();
            start_pc = 0;
            cap_count = 1;
            hard_end = 1;
            start_off = 0;
            begins_line = 1;
            errors = 0;
            init_search();
        endfunction

        function void write_reg(bit [rtvm_pkg::CFG_IDX_W-1:0] idx,
                                bit [rtvm_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                rtvm_pkg::CFG_START_PC:    start_pc = data[5:0];
                rtvm_pkg::CFG_CAP_COUNT:   cap_count = data[3:0];
                rtvm_pkg::CFG_HARD_END:    hard_end = data[0];
                rtvm_pkg::CFG_START_OFF:   start_off = data;
                rtvm_pkg::CFG_BEGINS_LINE: begins_line = data[0];
                default:                   return;
            endcase
            if (steps == 0 && !done) load_string();
        endfunction

        function void run_char(bit [20:0] r, bit at_end);
            int unsigned a, b, cc, nc, pos, ms, k, n;
            bit [5:0]    pc, q;
            bit          keep, go;
            rtvm_pkg::t_instr ins, c;
            thread_s     fresh;
            a = cur & 1;
            b = a ^ 1;
            cc = cnt[a];
            nc = 0;
            pos = 0;
            ms = cap_slots();
            if (steps < 65535) steps++;
            visited = '0;
            if (mstep == 0 && cc < rtvm_pkg::MAX_THREADS) begin
                foreach (fresh.caps[k2]) fresh.caps[k2] = '0;
                fresh.pc = start_pc;
                fresh.gen = steps;
                lists[a][cc] = fresh;
                cc++;
            end
            while (pos < cc) begin
                pc = lists[a][pos].pc;
                keep = 0;
                go = 1;
                while (go) begin
                    if (visited[pc]) break;
                    visited[pc] = 1;
                    ins = prog[pc];
                    case (ins.op)
                        rtvm_pkg::OP_RUNE: begin
                            if (r == ins.lo) begin
                                pc = pc + 1;
                                keep = 1;
                            end
                            go = 0;
                        end
                        rtvm_pkg::OP_ANY: begin
                            pc = pc + 1;
                            keep = 1;
                            go = 0;
                        end
                        rtvm_pkg::OP_CLASS: begin
                            q = pc;
                            for (n = 0; n < rtvm_pkg::PROG_DEPTH; n++) begin
                                c = prog[q];
                                if (r < c.lo) break;
                                if (r > c.hi) begin
                                    q = q + 1;
                                    continue;
                                end
                                pc = c.ta;
                                keep = 1;
                                break;
                            end
                            go = 0;
                        end
                        rtvm_pkg::OP_NOTNL: begin
                            if (r != rtvm_pkg::CH_NEWLINE) pc = pc + 1;
                            else go = 0;
                        end
                        rtvm_pkg::OP_BOL: begin
                            if (prev_nl) pc = pc + 1;
                            else go = 0;
                        end
                        rtvm_pkg::OP_EOL: begin
                            if ((!at_end && r == rtvm_pkg::CH_NEWLINE) || (at_end && hard_end))
                                pc = pc + 1;
                            else go = 0;
                        end
                        rtvm_pkg::OP_JMP: pc = ins.ta;
                        rtvm_pkg::OP_SPLIT: begin
                            if ((cc - pos) + nc < rtvm_pkg::MAX_THREADS) begin
                                for (k = cc; k > pos + 1; k--) lists[a][k] = lists[a][k-1];
                                lists[a][pos+1] = lists[a][pos];
                                lists[a][pos+1].pc = ins.tb;
                                cc++;
                            end
                            pc = ins.ta;
                        end
                        rtvm_pkg::OP_SAVE: begin
                            if (ins.sub < ms) begin
                                lists[a][pos].caps[ins.sub].sp = offset;
                                lists[a][pos].caps[ins.sub].sset = 1;
                            end
                            pc = pc + 1;
                        end
                        rtvm_pkg::OP_UNSAVE: begin
                            if (ins.sub == 0) begin
                                mstep = lists[a][pos].gen;
                                if (ms > 0) begin
                                    mcap = lists[a][pos].caps;
                                    mcap[0].ep = offset;
                                    mcap[0].eset = 1;
                                end
                                go = 0;
                            end else begin
                                if (ins.sub < ms) begin
                                    lists[a][pos].caps[ins.sub].ep = offset;
                                    lists[a][pos].caps[ins.sub].eset = 1;
                                end
                                pc = pc + 1;
                            end
                        end
                        default: go = 0;
                    endcase
                end
                if (keep && nc < rtvm_pkg::MAX_THREADS) begin
                    lists[b][nc] = lists[a][pos];
                    lists[b][nc].pc = pc;
                    nc++;
                end
                pos++;
                if (pos < cc && mstep != 0 && lists[a][pos].gen > mstep) break;
            end
            cnt[a] = 0;
            cnt[b] = nc;
            cur = cur ^ 1;
        endfunction

        function void push_captures();
            int unsigned ms, n, k;
            capture_s    e;
            ms = cap_slots();
            n = (ms == 0) ? 1 : ms;
            for (k = 0; k < n; k++) begin
                e.matched   = (mstep != 0);
                e.slot      = k[2:0];
                e.cap_start = (ms > 0) ? mcap[k].sp : 16'd0;
                e.cap_end   = (ms > 0) ? mcap[k].ep : 16'd0;
                e.start_set = (ms > 0) && mcap[k].sset;
                e.end_set   = (ms > 0) && mcap[k].eset;
                e.last      = (k + 1 == n);
                expected_caps.push_back(e);
            end
        endfunction

        function void note_item(item_s it);
            int unsigned sum;
            rtvm_pkg::t_instr ins;
            if (!it.cmd) begin
                ins.op = it.op;
                ins.lo = it.lo;
                ins.hi = it.hi;
                ins.ta = it.ta;
                ins.tb = it.tb;
                ins.sub = it.sub;
                prog[it.idx] = ins;
                return;
            end
            if (it.is_end) begin
                if (!done) begin
                    run_char(21'd0, 1'b1);
                    push_captures();
                end
                init_search();
                return;
            end
            if (done) return;
            sum = offset + it.nbytes;
            run_char(it.code, 1'b0);
            offset = (sum > 65535) ? 65535 : sum;
            prev_nl = (it.code == rtvm_pkg::CH_NEWLINE);
            if (mstep != 0 && cnt[cur & 1] == 0) begin
                done = 1;
                push_captures();
            end
        endfunction

        function void check_result(capture_s got);
            capture_s e;
            if (expected_caps.size() == 0) begin
                $error("unexpected result transaction, slot %0d", got.slot);
                errors++;
                return;
            end
            e = expected_caps.pop_front();
            if (got.matched != e.matched) begin
                $error("matched: expected %0d, got %0d", e.matched, got.matched);
                errors++;
            end
            if (got.slot != e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, got.slot);
                errors++;
            end
            if (got.cap_start != e.cap_start) begin
                $error("cap_start: expected %0d, got %0d", e.cap_start, got.cap_start);
                errors++;
            end
            if (got.cap_end != e.cap_end) begin
                $error("cap_end: expected %0d, got %0d", e.cap_end, got.cap_end);
                errors++;
            end
            if (got.start_set != e.start_set) begin
                $error("start_set: expected %0d, got %0d", e.start_set, got.start_set);
                errors++;
            end
            if (got.end_set != e.end_set) begin
                $error("end_set: expected %0d, got %0d", e.end_set, got.end_set);
                errors++;
            end
            if (got.last != e.last) begin
                $error("last: expected %0d, got %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 400000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic                 i_command = 0;
    logic [5:0]           i_instr_index = 0;
    logic [3:0]           i_instr_op = 0;
    logic [20:0]          i_instr_low = 0;
    logic [20:0]          i_instr_high = 0;
    logic [5:0]           i_instr_target_a = 0;
    logic [5:0]           i_instr_target_b = 0;
    logic [4:0]           i_instr_sub = 0;
    logic [20:0]          i_char_code = 0;
    logic [2:0]           i_char_bytes = 1;
    logic                 i_is_end = 0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic                 o_matched;
    logic [2:0]           o_slot;
    logic [rtvm_pkg::OFF_W-1:0]     o_cap_start;
    logic [rtvm_pkg::OFF_W-1:0]     o_cap_end;
    logic                 o_start_set;
    logic                 o_end_set;
    logic                 o_last;
    logic                 i_cfg_we = 0;
    logic [rtvm_pkg::CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [rtvm_pkg::CFG_DAT_W-1:0] i_cfg_data = 0;

    match_scoreboard sb = new();
    bit              calm = 0;
    int              quiet_cycles = 0;

    regex_thread_vm_matcher_top dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_matched, o_slot, o_cap_start, o_cap_end,
                              o_start_set, o_end_set, o_last});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("regex_thread_vm_matcher_top_test: done, errors");
            $finish;
        end
    end

    function automatic item_s filler();
        item_s it;
        it.cmd    = $urandom_range(0, 1);
        it.idx    = $urandom_range(0, 63);
        it.op     = $urandom_range(0, 9);
        it.lo     = $urandom_range(0, 1114111);
        it.hi     = $urandom_range(0, 1114111);
        it.ta     = $urandom_range(0, 63);
        it.tb     = $urandom_range(0, 63);
        it.sub    = $urandom_range(0, 31);
        it.code   = $urandom_range(0, 1114111);
        it.nbytes = $urandom_range(1, 4);
        it.is_end = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic bit [20:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 21'h61 + $urandom_range(0, 2);
        if (r < 85) return rtvm_pkg::CH_NEWLINE;
        if (r < 90) return 21'd0;
        return $urandom_range(0, 1114111);
    endfunction

    function automatic item_s load_op(int slot, bit [3:0] op, int lo, int hi,
                                      int ta, int tb, int sub);
        item_s it;
        it = filler();
        it.cmd = 0;
        it.idx = slot;
        it.op = op;
        it.lo = lo;
        it.hi = hi;
        it.ta = ta;
        it.tb = tb;
        it.sub = sub;
        return it;
    endfunction

    function automatic item_s rand_instr(int slot);
        item_s it;
        int    w;
        bit [3:0] op;
        w = $urandom_range(0, 99);
        if      (w < 24) op = rtvm_pkg::OP_RUNE;
        else if (w < 31) op = rtvm_pkg::OP_ANY;
        else if (w < 41) op = rtvm_pkg::OP_CLASS;
        else if (w < 45) op = rtvm_pkg::OP_NOTNL;
        else if (w < 49) op = rtvm_pkg::OP_BOL;
        else if (w < 53) op = rtvm_pkg::OP_EOL;
        else if (w < 61) op = rtvm_pkg::OP_JMP;
        else if (w < 75) op = rtvm_pkg::OP_SPLIT;
        else if (w < 86) op = rtvm_pkg::OP_SAVE;
        else if (w < 98) op = rtvm_pkg::OP_UNSAVE;
        else             op = $urandom_range(10, 15);
        it = load_op(slot, op, pick_char(), 0,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : (slot + $urandom_range(0, 6)) % 64,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : (slot + $urandom_range(0, 6)) % 64,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 9));
        if (op == rtvm_pkg::OP_UNSAVE && $urandom_range(0, 1)) it.sub = 0;
        if ($urandom_range(0, 19) == 0) it.lo = $urandom_range(0, 1114111);
        it.hi = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1114111)
                                             : it.lo + $urandom_range(0, 3);
        return it;
    endfunction

    task automatic send_item(item_s it);
        if (!calm && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_command        <= it.cmd;
        i_instr_index    <= it.idx;
        i_instr_op       <= it.op;
        i_instr_low      <= it.lo;
        i_instr_high     <= it.hi;
        i_instr_target_a <= it.ta;
        i_instr_target_b <= it.tb;
        i_instr_sub      <= it.sub;
        i_char_code      <= it.code;
        i_char_bytes     <= it.nbytes;
        i_is_end         <= it.is_end;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
    endtask

    task automatic send_char(bit [20:0] code, bit [2:0] nbytes, bit is_end);
        item_s it;
        it = filler();
        it.cmd = 1;
        it.code = code;
        it.nbytes = nbytes;
        it.is_end = is_end;
        send_item(it);
    endtask

    task automatic send_string(int len);
        for (int i = 0; i < len; i++) send_char(pick_char(), $urandom_range(1, 4), 1'b0);
        send_char($urandom_range(0, 1114111), $urandom_range(1, 4), 1'b1);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_caps.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [rtvm_pkg::CFG_IDX_W-1:0] idx,
                             bit [rtvm_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic configure(int spc, int caps, int hend, int soff, int bol);
        write_reg(rtvm_pkg::CFG_START_PC, spc);
        write_reg(rtvm_pkg::CFG_CAP_COUNT, caps);
        write_reg(rtvm_pkg::CFG_HARD_END, hend);
        write_reg(rtvm_pkg::CFG_START_OFF, soff);
        write_reg(rtvm_pkg::CFG_BEGINS_LINE, bol);
    endtask

    initial begin
        int sent;
        sb.reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(0, 3, 1, 0, 1);
        for (int s = 0; s < 64; s++) send_item(rand_instr(s));

        // directed program: (a[b-dx-z]*) with ignored slots, plus a line anchored one
        send_item(load_op(0, rtvm_pkg::OP_SAVE, 0, 0, 0, 0, 0));
        send_item(load_op(1, rtvm_pkg::OP_SAVE, 0, 0, 0, 0, 1));
        send_item(load_op(2, rtvm_pkg::OP_RUNE, 'h61, 0, 0, 0, 0));
        send_item(load_op(3, rtvm_pkg::OP_SPLIT, 0, 0, 4, 6, 0));
        send_item(load_op(4, rtvm_pkg::OP_CLASS, 'h62, 'h64, 3, 0, 0));
        send_item(load_op(5, rtvm_pkg::OP_CLASS, 'h78, 'h7a, 3, 0, 0));
        send_item(load_op(6, rtvm_pkg::OP_UNSAVE, 0, 0, 0, 0, 1));
        send_item(load_op(7, rtvm_pkg::OP_SAVE, 0, 0, 0, 0, 9));
        send_item(load_op(8, rtvm_pkg::OP_UNSAVE, 0, 0, 0, 0, 0));
        send_item(load_op(10, rtvm_pkg::OP_BOL, 0, 0, 0, 0, 0));
        send_item(load_op(11, rtvm_pkg::OP_NOTNL, 0, 0, 0, 0, 0));
        send_item(load_op(12, rtvm_pkg::OP_EOL, 0, 0, 0, 0, 0));
        send_item(load_op(13, rtvm_pkg::OP_UNSAVE, 0, 0, 0, 0, 0));
        send_char('h71, 1, 0);
        send_char('h61, 4, 0);
        send_char('h79, 2, 0);
        send_char(21'd0, 1, 0);
        send_char(21'h10ffff, 1, 1);
        settle();
        configure(10, 0, 1, 65534, 1);
        send_char(21'd0, 1, 1);
        send_char(rtvm_pkg::CH_NEWLINE, 3, 0);
        send_char(21'h1fffff, 4, 1);
        settle();
        configure(10, 8, 0, 65535, 0);
        send_char(rtvm_pkg::CH_NEWLINE, 4, 0);
        send_char(21'd0, 1, 1);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            calm = (ph == 3);
            configure((ph == 0) ? 0 : (ph == 1) ? 63 : $urandom_range(0, 63),
                      (ph == 0) ? 0 : (ph == 1) ? 8 : (ph == 5) ? 12 : $urandom_range(1, 8),
                      ph % 2,
                      (ph == 0) ? 0 : (ph == 1) ? 65535 : (ph == 2) ? 65520
                                                        : $urandom_range(0, 65535),
                      (ph >> 1) & 1);
            sent = 0;
            for (int n = $urandom_range(10, 16); n > 0; n--) begin
                send_item(rand_instr($urandom_range(0, 63)));
                sent++;
            end
            while (sent < 30) begin
                int len;
                len = $urandom_range(0, 10);
                send_string(len);
                sent += len + 1;
                if ($urandom_range(0, 4) == 0) begin
                    settle();
                    write_reg(rtvm_pkg::CFG_START_OFF, $urandom_range(0, 65535));
                    write_reg(rtvm_pkg::CFG_BEGINS_LINE, $urandom_range(0, 1));
                end
            end
        end
        calm = 0;

        i_valid <= 1'b0;
        while (sb.expected_caps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("regex_thread_vm_matcher_top_test: done, clean");
        end else begin
            $display("regex_thread_vm_matcher_top_test: done, errors");
        end
        $finish;
    end

endmodule
